FILE: rtl/psr_pkg.sv
// Shared types and constants for the perfect square root block.
// No dependencies; every other file imports this package.
package psr_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned RootWidth  = 32;
  // Partial remainder never exceeds twice the partial root.
  localparam int unsigned RemWidth   = RootWidth + 1;
  // One root bit (two radicand bits) is settled per step.
  localparam int unsigned StepCount  = RootWidth;
  localparam int unsigned CntWidth   = $clog2(StepCount);

  typedef enum logic [1:0] {
    PSR_IDLE,
    PSR_RUN,
    PSR_DONE
  } psr_state_t;

  // Requests from the top level to the root engine.
  typedef struct packed {
    logic start;
    logic take;
  } psr_ctrl_t;

  // Status from the root engine to the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } psr_stat_t;

endpackage

FILE: rtl/psr_if.sv
// Valid/ready channel interfaces for the input values and the resulting roots.
// Depends on psr_pkg for the field widths.
interface psr_in_if
  import psr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface psr_out_if
  import psr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [RootWidth-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

FILE: rtl/perfect_square_root.sv
// Top level of the perfect square root block: input channel, root engine
// and output register. Depends on psr_pkg, psr_if.sv and psr_core.
//
// Usage:
//   in_ch carries one signed 64-bit value per transfer; out_ch returns one
//   32-bit root per value, in order. The root is exact when the value is a
//   positive perfect square and 0 for zero, negative values and non-squares.
//   After the input transfer the engine runs its 32 root steps; the result
//   then moves into the output register, which raises out_ch.valid.
//   The engine settles one root bit per cycle by a single 35-bit trial
//   subtraction, and works on one value at a time: it takes the next value
//   only after its root has moved into the output register.
//   The output register parts the two sides: a new value is taken while the
//   previous root still waits on out_ch. If the receiver stalls longer, the
//   finished engine holds its result and in_ch.ready stays low.
//   Reset (rst_n low, synchronous) empties the engine and the output
//   register; no state is kept between values.
module perfect_square_root
  import psr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  psr_in_if.sink   in_ch,
  psr_out_if.source out_ch
);

  psr_ctrl_t            ctrl;
  psr_stat_t            stat;
  logic [RootWidth-1:0] core_root;

  logic                 out_valid_r, out_valid_nxt;
  logic [RootWidth-1:0] out_root_r, out_root_nxt;
  logic                 load;

  psr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .value (in_ch.value),
    .stat  (stat),
    .root  (core_root)
  );

  assign in_ch.ready = stat.idle;
  // The output register takes a result when it is empty or being emptied.
  assign load        = stat.done && (!out_valid_r || out_ch.ready);
  assign ctrl.start  = in_ch.valid && in_ch.ready;
  assign ctrl.take   = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_root_nxt  = out_root_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_root_nxt  = core_root;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_root_r <= out_root_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.root  = out_root_r;

endmodule

FILE: rtl/psr_core.sv
// Bit-serial restoring square root engine with an exact-square test.
// Depends on psr_pkg for widths, the state type and the control structs.
module psr_core
  import psr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  psr_ctrl_t             ctrl,
  input  logic [ValueWidth-1:0] value,
  output psr_stat_t             stat,
  output logic [RootWidth-1:0]  root
);

  localparam logic [CntWidth-1:0] LastStep = CntWidth'(StepCount - 1);

  psr_state_t state_r, state_nxt;
  logic [CntWidth-1:0]   cnt_r, cnt_nxt;
  logic [ValueWidth-1:0] rad_r, rad_nxt;
  logic [RemWidth-1:0]   rem_r, rem_nxt;
  logic [RootWidth-1:0]  root_r, root_nxt;
  logic                  neg_r, neg_nxt;

  logic [RemWidth+1:0]   rem_sh;
  logic [RemWidth+1:0]   trial;
  logic [RemWidth+2:0]   diff;
  logic                  fits;

  // Bring down the next radicand pair and try (4*root + 1) against it.
  assign rem_sh = {rem_r, rad_r[ValueWidth-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign fits   = ~diff[RemWidth+2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PSR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    neg_r  <= neg_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      PSR_IDLE: begin
        if (ctrl.start) begin
          rad_nxt   = value;
          rem_nxt   = '0;
          root_nxt  = '0;
          neg_nxt   = value[ValueWidth-1];
          cnt_nxt   = '0;
          state_nxt = PSR_RUN;
        end
      end
      PSR_RUN: begin
        rad_nxt = {rad_r[ValueWidth-3:0], 2'b00};
        if (fits) begin
          rem_nxt  = diff[RemWidth-1:0];
          root_nxt = {root_r[RootWidth-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[RemWidth-1:0];
          root_nxt = {root_r[RootWidth-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LastStep) begin
          state_nxt = PSR_DONE;
        end
      end
      PSR_DONE: begin
        if (ctrl.take) begin
          state_nxt = PSR_IDLE;
        end
      end
      default: state_nxt = PSR_IDLE;
    endcase
  end

  assign stat.idle = (state_r == PSR_IDLE);
  assign stat.done = (state_r == PSR_DONE);

  // Zero also lands here with a zero root, so it needs no case of its own.
  assign root = (neg_r || (rem_r != '0)) ? '0 : root_r;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> state_r == PSR_IDLE)
    else $error("start requested while the engine is busy");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PSR_RUN && cnt_r == LastStep) |=> state_r == PSR_DONE)
    else $error("engine did not finish after the last step");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == PSR_RUN |-> {1'b0, rem_r} <= {root_r, 1'b0})
    else $error("partial remainder exceeds twice the partial root");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PSR_DONE && !ctrl.take) |=> (state_r == PSR_DONE && $stable(root)))
    else $error("finished result changed before it was taken");

endmodule
